FILE: rtl/assert_macros.svh
// Assertion macros shared by the wah filter modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/svfw_pkg.sv
// Shared types, constants and saturation helpers for the stereo wah filter.
// Used by svfw_mul, svfw_chan and stereo_svf_bandpass_wah_top; depends on nothing.
package svfw_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int STATE_BITS     = 32;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

  // The multiplier consumes the coefficient one digit per cycle.
  localparam int DIGIT_BITS     = 4;
  localparam int NUM_DIGITS     = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int COEF_PAD_BITS  = NUM_DIGITS * DIGIT_BITS;
  localparam int CNT_BITS       = $clog2(NUM_DIGITS + 1);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  localparam logic [COEF_BITS-1:0] GAIN_RESET = COEF_BITS'(356873);
  localparam logic [COEF_BITS-1:0] DAMP_RESET = COEF_BITS'(4760891);
  localparam logic [COEF_BITS-1:0] NORM_RESET = COEF_BITS'(3824903);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE,
    REG_GAIN,
    REG_DAMP,
    REG_NORM
  } cfg_reg_t;

  typedef logic signed [STATE_BITS-1:0]  state_word_t;
  typedef logic signed [SAMPLE_BITS-1:0] pcm_word_t;
  typedef logic [COEF_BITS-1:0]          coef_t;

  localparam state_word_t STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam state_word_t STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam pcm_word_t   SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam pcm_word_t   SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    coef_t gain;
    coef_t damp;
    coef_t norm;
  } coef_set_t;

  typedef struct packed {
    logic        start;
    coef_t       coef;
    state_word_t operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    state_word_t result;
  } mul_rsp_t;

  typedef struct packed {
    logic      done;
    pcm_word_t y;
  } chan_rsp_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_last_out;
  } out_word_t;

  // Add or subtract two state words, saturating to the state range.
  function automatic state_word_t sat_add(input state_word_t a, input state_word_t b,
                                          input logic sub);
    logic signed [STATE_BITS:0] ext_a;
    logic signed [STATE_BITS:0] ext_b;
    logic signed [STATE_BITS:0] sum;
    state_word_t                res;
    ext_a = {a[STATE_BITS-1], a};
    ext_b = {b[STATE_BITS-1], b};
    sum   = sub ? (ext_a - ext_b) : (ext_a + ext_b);
    if (sum[STATE_BITS] != sum[STATE_BITS-1]) begin
      res = sum[STATE_BITS] ? STATE_MIN : STATE_MAX;
    end else begin
      res = sum[STATE_BITS-1:0];
    end
    return res;
  endfunction

  // Saturate a state word to the sample range.
  function automatic pcm_word_t sat_sample(input state_word_t v);
    logic      fits;
    pcm_word_t res;
    fits = (&v[STATE_BITS-1:SAMPLE_BITS-1]) || !(|v[STATE_BITS-1:SAMPLE_BITS-1]);
    if (fits) begin
      res = v[SAMPLE_BITS-1:0];
    end else begin
      res = v[STATE_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return res;
  endfunction

endpackage

FILE: rtl/svfw_mul.sv
// Digit-serial coefficient multiplier: state word times unsigned coefficient,
// rounded and saturated to the state range. Depends on svfw_pkg.
module svfw_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  svfw_pkg::mul_req_t req,
  output svfw_pkg::mul_rsp_t rsp
);

  `include "assert_macros.svh"

  localparam int PP_BITS   = svfw_pkg::STATE_BITS + svfw_pkg::DIGIT_BITS + 1;
  localparam int PROD_BITS = svfw_pkg::STATE_BITS + svfw_pkg::COEF_PAD_BITS + 1;
  localparam int SH_BITS   = PROD_BITS + 1 - svfw_pkg::COEF_FRAC_BITS;
  localparam logic signed [PROD_BITS:0] RND_HALF =
    (PROD_BITS+1)'(64'd1 << (svfw_pkg::COEF_FRAC_BITS - 1));

  logic [svfw_pkg::COEF_PAD_BITS-1:0]  coef_sr_r;
  svfw_pkg::state_word_t               v_r;
  logic signed [PROD_BITS-1:0]         acc_r;
  logic signed [PROD_BITS-1:0]         acc_nxt;
  logic [svfw_pkg::CNT_BITS-1:0]       cnt_r;
  logic                                busy_r;
  logic                                fin_r;
  logic                                done_r;
  svfw_pkg::state_word_t               result_r;

  logic [svfw_pkg::DIGIT_BITS-1:0]     digit;
  logic signed [PP_BITS-1:0]           pp;
  logic signed [PROD_BITS:0]           rnd;
  logic signed [SH_BITS-1:0]           sh;
  logic                                sh_fits;
  svfw_pkg::state_word_t               sat_res;

  // Most significant digit first: shift the running sum up one digit and
  // add the operand times the next digit.
  always_comb begin
    digit   = coef_sr_r[svfw_pkg::COEF_PAD_BITS-1 -: svfw_pkg::DIGIT_BITS];
    pp      = PP_BITS'(v_r) * PP_BITS'($signed({1'b0, digit}));
    acc_nxt = (acc_r <<< svfw_pkg::DIGIT_BITS) + PROD_BITS'(pp);
  end

  // Round half up, drop the fraction bits, then saturate.
  always_comb begin
    rnd     = (PROD_BITS+1)'(acc_r) + RND_HALF;
    sh      = rnd[PROD_BITS:svfw_pkg::COEF_FRAC_BITS];
    sh_fits = (&sh[SH_BITS-1:svfw_pkg::STATE_BITS-1]) ||
              !(|sh[SH_BITS-1:svfw_pkg::STATE_BITS-1]);
    if (sh_fits) begin
      sat_res = sh[svfw_pkg::STATE_BITS-1:0];
    end else begin
      sat_res = sh[SH_BITS-1] ? svfw_pkg::STATE_MIN : svfw_pkg::STATE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        coef_sr_r <= svfw_pkg::COEF_PAD_BITS'(req.coef);
        v_r       <= req.operand;
        acc_r     <= '0;
        cnt_r     <= svfw_pkg::CNT_BITS'(svfw_pkg::NUM_DIGITS);
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        acc_r     <= acc_nxt;
        coef_sr_r <= coef_sr_r << svfw_pkg::DIGIT_BITS;
        cnt_r     <= cnt_r - svfw_pkg::CNT_BITS'(1);
        if (cnt_r == svfw_pkg::CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        result_r <= sat_res;
        fin_r    <= 1'b0;
        done_r   <= 1'b1;
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

  `ASSERT_ALWAYS(a_no_restart, !(req.start && (busy_r || fin_r)), "multiplier restarted mid-run")

endmodule

FILE: rtl/svfw_chan.sv
// One channel of the trapezoidal state variable filter: integrator state,
// operation sequencer and a digit-serial multiplier. Depends on svfw_pkg, svfw_mul.
module svfw_chan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  svfw_pkg::pcm_word_t  x,
  input  svfw_pkg::coef_set_t  coefs,
  output svfw_pkg::chan_rsp_t  rsp
);

  typedef enum logic [3:0] {
    C_IDLE,
    C_MUL_G1,
    C_SUB_X,
    C_SUB_Z2,
    C_MUL_D,
    C_MUL_GHP,
    C_ADD_BP,
    C_MUL_GBP,
    C_ADD_LP,
    C_UPDATE
  } state_t;

  state_t                state_r;
  logic                  start_r;
  logic                  done_r;
  svfw_pkg::pcm_word_t   y_r;
  svfw_pkg::state_word_t z1_r;
  svfw_pkg::state_word_t z2_r;
  svfw_pkg::state_word_t x_r;
  svfw_pkg::state_word_t t_r;
  svfw_pkg::state_word_t ghp_r;
  svfw_pkg::state_word_t bp_r;
  svfw_pkg::state_word_t gbp_r;
  svfw_pkg::state_word_t lp_r;

  svfw_pkg::mul_req_t mul_req;
  svfw_pkg::mul_rsp_t mul_rsp;

  // The operands are chosen by the multiply step in progress; the multiplier
  // captures them in the cycle that start is high.
  always_comb begin
    mul_req.start   = start_r;
    mul_req.coef    = coefs.gain;
    mul_req.operand = bp_r;
    unique case (state_r)
      C_MUL_G1: begin
        mul_req.coef    = coefs.damp;
        mul_req.operand = z1_r;
      end
      C_MUL_D: begin
        mul_req.coef    = coefs.norm;
        mul_req.operand = t_r;
      end
      C_MUL_GHP: begin
        mul_req.coef    = coefs.gain;
        mul_req.operand = t_r;
      end
      default: begin
        mul_req.coef    = coefs.gain;
        mul_req.operand = bp_r;
      end
    endcase
  end

  svfw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      start_r <= 1'b0;
      done_r  <= 1'b0;
      z1_r    <= '0;
      z2_r    <= '0;
    end else begin
      start_r <= 1'b0;
      done_r  <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (go) begin
            x_r     <= svfw_pkg::STATE_BITS'(x);
            start_r <= 1'b1;
            state_r <= C_MUL_G1;
          end
        end
        C_MUL_G1: begin
          if (mul_rsp.done) begin
            t_r     <= mul_rsp.result;
            state_r <= C_SUB_X;
          end
        end
        C_SUB_X: begin
          t_r     <= svfw_pkg::sat_add(x_r, t_r, 1'b1);
          state_r <= C_SUB_Z2;
        end
        C_SUB_Z2: begin
          t_r     <= svfw_pkg::sat_add(t_r, z2_r, 1'b1);
          start_r <= 1'b1;
          state_r <= C_MUL_D;
        end
        C_MUL_D: begin
          // The high-pass value replaces the bracketed sum in t_r.
          if (mul_rsp.done) begin
            t_r     <= mul_rsp.result;
            start_r <= 1'b1;
            state_r <= C_MUL_GHP;
          end
        end
        C_MUL_GHP: begin
          if (mul_rsp.done) begin
            ghp_r   <= mul_rsp.result;
            state_r <= C_ADD_BP;
          end
        end
        C_ADD_BP: begin
          bp_r    <= svfw_pkg::sat_add(ghp_r, z1_r, 1'b0);
          start_r <= 1'b1;
          state_r <= C_MUL_GBP;
        end
        C_MUL_GBP: begin
          if (mul_rsp.done) begin
            gbp_r   <= mul_rsp.result;
            state_r <= C_ADD_LP;
          end
        end
        C_ADD_LP: begin
          lp_r    <= svfw_pkg::sat_add(gbp_r, z2_r, 1'b0);
          state_r <= C_UPDATE;
        end
        C_UPDATE: begin
          z1_r    <= svfw_pkg::sat_add(ghp_r, bp_r, 1'b0);
          z2_r    <= svfw_pkg::sat_add(gbp_r, lp_r, 1'b0);
          y_r     <= svfw_pkg::sat_sample(bp_r);
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.y    = y_r;

endmodule

FILE: rtl/stereo_svf_bandpass_wah_top.sv
// Stereo band-pass wah: two state variable filter lanes run side by side.
// Filtering: each word runs through four sequential passes of each lane's digit multiplier,
// and no new word is taken until the last result is in the output register.
// Pass-through (enable low): the input word is registered and sent on through T_WAIT.
// Synchronous active-low reset clears the integrators and loads the default coefficients.
// Depends on svfw_pkg and svfw_chan.
module stereo_svf_bandpass_wah_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  svfw_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output svfw_pkg::out_word_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [svfw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [svfw_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_WAIT
  } state_t;

  state_t              state_r;
  logic                enable_r;
  svfw_pkg::coef_set_t coefs_r;
  svfw_pkg::in_word_t  in_r;
  logic                bypass_r;
  logic                out_valid_r;
  svfw_pkg::out_word_t out_data_r;

  logic                accept;
  logic                go;
  svfw_pkg::chan_rsp_t l_rsp;
  svfw_pkg::chan_rsp_t r_rsp;
  svfw_pkg::out_word_t result;

  assign in_ready = (state_r == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign go       = accept && enable_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      coefs_r.gain  <= svfw_pkg::GAIN_RESET;
      coefs_r.damp  <= svfw_pkg::DAMP_RESET;
      coefs_r.norm  <= svfw_pkg::NORM_RESET;
    end else if (cfg_we) begin
      unique case (svfw_pkg::cfg_reg_t'(cfg_index))
        svfw_pkg::REG_ENABLE: enable_r     <= cfg_wdata[0];
        svfw_pkg::REG_GAIN:   coefs_r.gain <= cfg_wdata[svfw_pkg::COEF_BITS-1:0];
        svfw_pkg::REG_DAMP:   coefs_r.damp <= cfg_wdata[svfw_pkg::COEF_BITS-1:0];
        svfw_pkg::REG_NORM:   coefs_r.norm <= cfg_wdata[svfw_pkg::COEF_BITS-1:0];
      endcase
    end
  end

  svfw_chan u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .x     (in_data.left_in),
    .coefs (coefs_r),
    .rsp   (l_rsp)
  );

  svfw_chan u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .x     (in_data.right_in),
    .coefs (coefs_r),
    .rsp   (r_rsp)
  );

  // The lane outputs hold until the next start, so the result can be built late.
  always_comb begin
    result.block_last_out = in_r.block_last;
    if (bypass_r) begin
      result.left_out  = in_r.left_in;
      result.right_out = in_r.right_in;
    end else begin
      result.left_out  = l_rsp.y;
      result.right_out = r_rsp.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      bypass_r    <= 1'b0;
    end else begin
      // A new word loaded from T_WAIT takes over the output register itself.
      if (out_valid_r && out_ready && state_r != T_WAIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            in_r     <= in_data;
            bypass_r <= !enable_r;
            state_r  <= enable_r ? T_RUN : T_WAIT;
          end
        end
        T_RUN: begin
          if (l_rsp.done) begin
            state_r <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= result;
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_lanes_lockstep, l_rsp.done == r_rsp.done, "filter lanes finished apart")
  `ASSERT_IMPLY(a_done_in_run, l_rsp.done, state_r == T_RUN, "lane finished outside a run")
  `ASSERT_IMPLY(a_out_from_wait, $rose(out_valid_r), $past(state_r == T_WAIT), "output word without a result")

endmodule

FILE: verif/tb_stereo_svf_bandpass_wah_top.sv
// Self-checking testbench for the stereo band-pass wah filter.
// It predicts every output word with a bit-exact software copy of both filter lanes.
// Depends on svfw_pkg and stereo_svf_bandpass_wah_top.
`timescale 1ns / 100ps

module tb_stereo_svf_bandpass_wah_top;

  localparam int  RANDOM_WORDS = 1650;
  localparam int  MAX_WAIT     = 6;
  localparam int  HOLD_CYCLES  = 300;
  // Worst honest gap between two handshakes is one filter pass plus a full receiver
  // hold-off and the longest random waits; this allows several times that.
  localparam int  QUIET_LIMIT  = 3000;
  localparam real SAMPLE_RATE  = 48000.0;
  localparam real COEF_ONE     = 4194304.0;

  typedef enum int {SIG_TONE, SIG_NOISE, SIG_QUIET, SIG_SQUARE} signal_kind_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  svfw_pkg::in_word_t                  in_data = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  svfw_pkg::out_word_t                 out_data;
  logic                                cfg_we = 1'b0;
  logic [svfw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [svfw_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // Software copy of the register file and of the four integrators.
  logic            cur_enable = 1'b0;
  svfw_pkg::coef_t cur_gain = svfw_pkg::GAIN_RESET;
  svfw_pkg::coef_t cur_damp = svfw_pkg::DAMP_RESET;
  svfw_pkg::coef_t cur_norm = svfw_pkg::NORM_RESET;
  longint          integ_one[2] = '{0, 0};
  longint          integ_two[2] = '{0, 0};

  svfw_pkg::in_word_t  pending_words[$];
  svfw_pkg::out_word_t expected_words[$];

  logic steady_flow = 1'b0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   accepted_words = 0;
  int   checked_words = 0;
  int   failures = 0;
  int   reg_writes = 0;
  int   phases_run = 0;
  int   quiet_cycles = 0;
  real  tone_period = 40.0;
  real  tone_amp = 4000000.0;

  stereo_svf_bandpass_wah_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint sat_to(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Coefficient product rounded half up, then held to the state range.
  function automatic longint coef_product(input svfw_pkg::coef_t c, input longint v);
    longint c_ext;
    longint p;
    c_ext = c;
    p = v * c_ext + (longint'(1) <<< (svfw_pkg::COEF_FRAC_BITS - 1));
    return sat_to(p >>> svfw_pkg::COEF_FRAC_BITS, svfw_pkg::STATE_BITS);
  endfunction

  function automatic longint svf_lane(input int lane, input longint x);
    longint t, hp, ghp, bp, gbp, lp;
    t = sat_to(x - coef_product(cur_damp, integ_one[lane]), svfw_pkg::STATE_BITS);
    t = sat_to(t - integ_two[lane], svfw_pkg::STATE_BITS);
    hp = coef_product(cur_norm, t);
    ghp = coef_product(cur_gain, hp);
    bp = sat_to(ghp + integ_one[lane], svfw_pkg::STATE_BITS);
    gbp = coef_product(cur_gain, bp);
    lp = sat_to(gbp + integ_two[lane], svfw_pkg::STATE_BITS);
    integ_one[lane] = sat_to(ghp + bp, svfw_pkg::STATE_BITS);
    integ_two[lane] = sat_to(gbp + lp, svfw_pkg::STATE_BITS);
    return sat_to(bp, svfw_pkg::SAMPLE_BITS);
  endfunction

  function automatic svfw_pkg::out_word_t predict_bandpass(input svfw_pkg::in_word_t w);
    svfw_pkg::out_word_t r;
    longint              xl;
    longint              xr;
    xl = w.left_in;
    xr = w.right_in;
    if (cur_enable) begin
      r.left_out  = svfw_pkg::pcm_word_t'(svf_lane(0, xl));
      r.right_out = svfw_pkg::pcm_word_t'(svf_lane(1, xr));
    end else begin
      r.left_out  = w.left_in;
      r.right_out = w.right_in;
    end
    r.block_last_out = w.block_last;
    return r;
  endfunction

  function automatic svfw_pkg::in_word_t make_word(input signal_kind_t kind, input int n);
    svfw_pkg::in_word_t w;
    real                ph;
    case (kind)
      SIG_TONE: begin
        ph = 6.283185307179586 * n / tone_period;
        w.left_in  = svfw_pkg::pcm_word_t'($rtoi(tone_amp * $sin(ph)) +
                                           $urandom_range(0, 63) - 32);
        w.right_in = svfw_pkg::pcm_word_t'($rtoi(tone_amp * $cos(0.7 * ph)) +
                                           $urandom_range(0, 63) - 32);
      end
      SIG_NOISE: begin
        w.left_in  = svfw_pkg::pcm_word_t'($urandom);
        w.right_in = svfw_pkg::pcm_word_t'($urandom);
      end
      SIG_QUIET: begin
        w.left_in  = svfw_pkg::pcm_word_t'($urandom_range(0, 8191) - 4096);
        w.right_in = svfw_pkg::pcm_word_t'($urandom_range(0, 8191) - 4096);
      end
      default: begin
        w.left_in  = ((n / 8) % 2) ? svfw_pkg::SAMPLE_MAX : svfw_pkg::SAMPLE_MIN;
        w.right_in = ((n / 8) % 2) ? svfw_pkg::SAMPLE_MIN : svfw_pkg::SAMPLE_MAX;
      end
    endcase
    w.block_last = ($urandom_range(0, 15) == 0);
    return w;
  endfunction

  function automatic svfw_pkg::in_word_t pair(input svfw_pkg::pcm_word_t l,
                                              input svfw_pkg::pcm_word_t r,
                                              input logic last);
    svfw_pkg::in_word_t w;
    w.left_in    = l;
    w.right_in   = r;
    w.block_last = last;
    return w;
  endfunction

  // Sender: one word at a time from the pending queue, with a random gap after each outside steady flow.
  always @(posedge clk) begin
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(predict_bandpass(in_data));
        accepted_words++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          gap_left = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word, stalls at random and serves long hold-off requests.
  always @(posedge clk) begin
    int                  stall_left;
    int                  hold_left;
    svfw_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected output word L=%0d R=%0d last=%0b", out_data.left_out,
                     out_data.right_out, out_data.block_last_out);
        end else begin
          want = expected_words.pop_front();
          if (out_data.left_out !== want.left_out || out_data.right_out !== want.right_out ||
              out_data.block_last_out !== want.block_last_out) begin
            failures++;
            if (failures <= 10)
              $display("mismatch %0d: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                       checked_words, want.left_out, want.right_out, want.block_last_out,
                       out_data.left_out, out_data.right_out, out_data.block_last_out);
          end
        end
        checked_words++;
        stall_left = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_left == 0 && holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input svfw_pkg::cfg_reg_t idx,
                           input logic [svfw_pkg::CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      svfw_pkg::REG_ENABLE: cur_enable = value[0];
      svfw_pkg::REG_GAIN:   cur_gain = value;
      svfw_pkg::REG_DAMP:   cur_damp = value;
      svfw_pkg::REG_NORM:   cur_norm = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Enable carries random upper bits, which the block must ignore.
  task automatic write_enable(input logic en);
    write_reg(svfw_pkg::REG_ENABLE, {(svfw_pkg::CFG_DATA_BITS-1)'($urandom), en});
  endtask

  // Coefficients as software would derive them from pedal position and resonance.
  task automatic set_wah(input real pos, input real q);
    real g, r, g1, d;
    g  = 3.141592653589793 * (400.0 + 1800.0 * pos) / SAMPLE_RATE;
    r  = 1.0 - 0.95 * q;
    g1 = 2.0 * r + g;
    d  = 1.0 / (1.0 + 2.0 * r * g + g * g);
    write_reg(svfw_pkg::REG_GAIN, svfw_pkg::coef_t'($rtoi(g * COEF_ONE + 0.5)));
    write_reg(svfw_pkg::REG_DAMP, svfw_pkg::coef_t'($rtoi(g1 * COEF_ONE + 0.5)));
    write_reg(svfw_pkg::REG_NORM, svfw_pkg::coef_t'($rtoi(d * COEF_ONE + 0.5)));
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (8) @(posedge clk);
    phases_run++;
  endtask

  function automatic svfw_pkg::coef_t edge_coef();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return svfw_pkg::coef_t'($urandom);
    endcase
  endfunction

  initial begin
    int           sent;
    int           count;
    int           phase;
    signal_kind_t kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the block is bypassed: words must come back untouched.
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MAX, svfw_pkg::SAMPLE_MIN, 1'b0));
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MIN, svfw_pkg::SAMPLE_MAX, 1'b1));
    pending_words.push_back(pair('0, '1, 1'b0));
    pending_words.push_back(pair(24'h555555, 24'hAAAAAA, 1'b1));
    drain();

    // Default coefficients: impulse, silence, a full-scale step and its reversal.
    write_enable(1'b1);
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MAX, svfw_pkg::SAMPLE_MIN, 1'b0));
    repeat (3) pending_words.push_back(pair('0, '0, 1'b0));
    repeat (4) pending_words.push_back(pair(svfw_pkg::SAMPLE_MAX, svfw_pkg::SAMPLE_MAX, 1'b0));
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MIN, svfw_pkg::SAMPLE_MIN, 1'b1));
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MIN, svfw_pkg::SAMPLE_MAX, 1'b0));
    drain();

    // Largest gain and normalisation with no damping drives the integrators into saturation.
    write_reg(svfw_pkg::REG_GAIN, '1);
    write_reg(svfw_pkg::REG_DAMP, '0);
    write_reg(svfw_pkg::REG_NORM, '1);
    repeat (3) pending_words.push_back(pair(svfw_pkg::SAMPLE_MAX, svfw_pkg::SAMPLE_MIN, 1'b0));
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MIN, svfw_pkg::SAMPLE_MAX, 1'b1));
    drain();

    // All-zero coefficients, then a bypass with saturated state held.
    write_reg(svfw_pkg::REG_GAIN, '0);
    write_reg(svfw_pkg::REG_DAMP, '0);
    write_reg(svfw_pkg::REG_NORM, '0);
    pending_words.push_back(pair(svfw_pkg::SAMPLE_MAX, svfw_pkg::SAMPLE_MIN, 1'b1));
    pending_words.push_back(pair(24'h000001, 24'hFFFFFF, 1'b0));
    drain();
    write_enable(1'b0);
    pending_words.push_back(pair(24'h123456, 24'hEDCBA9, 1'b1));
    drain();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      count = $urandom_range(90, 180);
      if (count > RANDOM_WORDS - sent) count = RANDOM_WORDS - sent;
      steady_flow = (phase % 4 == 1);
      case (phase % 6)
        1: begin
          write_enable(1'b0);
        end
        3: begin
          write_reg(svfw_pkg::REG_GAIN, edge_coef());
          write_reg(svfw_pkg::REG_DAMP, edge_coef());
          write_reg(svfw_pkg::REG_NORM, edge_coef());
          write_enable(1'b1);
        end
        default: begin
          if (phase == 0) set_wah(0.0, 0.0);
          else if (phase == 2) set_wah(1.0, 1.0);
          else set_wah($urandom_range(0, 1000) / 1000.0, $urandom_range(0, 1000) / 1000.0);
          write_enable(1'b1);
        end
      endcase
      case ($urandom_range(0, 9))
        0: kind = SIG_NOISE;
        1: kind = SIG_QUIET;
        2: kind = SIG_SQUARE;
        default: kind = SIG_TONE;
      endcase
      tone_period = $urandom_range(6, 200);
      tone_amp = $urandom_range(1000, 8388000);
      for (int n = 0; n < count; n++) pending_words.push_back(make_word(kind, n));
      // Early on, hold the receiver off so the block backs up and stalls its input.
      if (phase == 2) hold_requests++;
      sent += count;
      drain();
      phase++;
    end

    repeat (60) @(posedge clk);
    failures += expected_words.size();
    $display("%0d words sent and %0d checked over %0d phases and %0d register writes",
             accepted_words, checked_words, phases_run, reg_writes);
    $display("stimulus spanned bypass, full-scale steps, tones, noise and saturating coefficients");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule
